[sv/crc16fc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fc_pkg
// Shared types, register codes and bit helpers for the CRC-16 frame checker.
// ----------------------------------------------------------------------------
package crc16fc_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_POLY         = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_REFLECT_POLY = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INIT_VALUE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REFLECT_IN   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REFLECT_OUT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_XOR_ENABLE   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_XOR_OUT      = 3'd6;

  // Reset values (Modbus flavor)
  localparam logic [15:0] PolyReset        = 16'h8005;
  localparam logic        ReflectPolyReset = 1'b1;
  localparam logic [15:0] InitValueReset   = 16'hFFFF;
  localparam logic        ReflectInReset   = 1'b0;
  localparam logic        ReflectOutReset  = 1'b0;
  localparam logic        XorEnableReset   = 1'b0;
  localparam logic [15:0] XorOutReset      = 16'h0000;

  // Front-to-back queue depth default
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [15:0] poly;
    logic        reflect_poly;
    logic [15:0] init_value;
    logic        reflect_in;
    logic        reflect_out;
    logic        xor_enable;
    logic [15:0] xor_out;
  } cfg_t;

  // One queued work entry: optional reload, optional byte fold, optional finish
  typedef struct packed {
    logic        restart;
    logic        fold;
    logic [7:0]  fold_byte;
    logic        last;
    logic [15:0] rx_crc;
    logic        short_frame;
  } op_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

  // Right-shifting byte update, eight bit steps
  function automatic logic [15:0] fold8(input logic [15:0] crc, input logic [7:0] b,
                                        input logic [15:0] p);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/crc16fc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fc_front
// Accepts frame bytes, runs the two-byte holding window and issues work ops.
// ----------------------------------------------------------------------------
module crc16fc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_frame_start,
  input  wire logic             in_frame_end,
  input  wire logic             q_full,
  output logic                  q_push,
  output crc16fc_pkg::op_t      q_op
);

  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic [7:0] h0, h1, w0, w1;
  logic [1:0] cnt0, cnt1;
  logic       fold;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    // frame start empties the window first
    cnt0 = in_frame_start ? 2'd0 : cnt_r;
    h0   = in_frame_start ? 8'h00 : held0_r;
    h1   = in_frame_start ? 8'h00 : held1_r;
    fold = (cnt0 == 2'd2);
    if (fold) begin
      w0   = h1;
      w1   = in_data_byte;
      cnt1 = 2'd2;
    end else begin
      w0   = cnt0[0] ? h0 : in_data_byte;
      w1   = cnt0[0] ? in_data_byte : h1;
      cnt1 = cnt0 + 2'd1;
    end

    q_op.restart     = in_frame_start;
    q_op.fold        = fold;
    q_op.fold_byte   = h0;
    q_op.last        = in_frame_end;
    q_op.rx_crc      = {w1, w0};
    q_op.short_frame = (cnt1 != 2'd2);

    held0_nxt = held0_r;
    held1_nxt = held1_r;
    cnt_nxt   = cnt_r;
    if (q_push) begin
      if (in_frame_end) begin
        held0_nxt = 8'h00;
        held1_nxt = 8'h00;
        cnt_nxt   = 2'd0;
      end else begin
        held0_nxt = w0;
        held1_nxt = w1;
        cnt_nxt   = cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held0_r <= 8'h00;
      held1_r <= 8'h00;
      cnt_r   <= 2'd0;
    end else begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/crc16fc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fc_queue
// Small show-ahead FIFO of work ops between front and back.
// ----------------------------------------------------------------------------
module crc16fc_queue #(
  parameter int unsigned DEPTH = crc16fc_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire crc16fc_pkg::op_t push_op,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output crc16fc_pkg::op_t      head_op
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  crc16fc_pkg::op_t mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_pop;

  assign full       = (cnt_r == FullCnt);
  assign head_valid = (cnt_r != '0);
  assign head_op    = mem_r[rd_ptr_r];
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrOne;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrOne;
    end
    unique case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CntOne;
      2'b01:   cnt_nxt = cnt_r - CntOne;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/crc16fc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fc_back
// Owns the CRC accumulator: folds bytes, finalizes and registers the result.
// ----------------------------------------------------------------------------
module crc16fc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire crc16fc_pkg::cfg_t cfg,
  input  wire logic             head_valid,
  input  wire crc16fc_pkg::op_t head_op,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_crc_match,
  output logic [15:0]           out_computed_crc,
  output logic                  out_short_frame
);

  logic [15:0] acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_match_r;
  logic [15:0] out_crc_r;
  logic        out_short_r;

  logic [15:0] p, acc0, acc1, fin;
  logic [7:0]  b;
  logic        slot_free;

  assign slot_free = ~out_valid_r | ~out_stall;
  // only finishing ops need the output slot
  assign pop = head_valid & (~head_op.last | slot_free);

  always_comb begin
    p    = cfg.reflect_poly ? crc16fc_pkg::rev16(cfg.poly) : cfg.poly;
    b    = cfg.reflect_in ? crc16fc_pkg::rev8(head_op.fold_byte) : head_op.fold_byte;
    acc0 = head_op.restart ? cfg.init_value : acc_r;
    acc1 = head_op.fold ? crc16fc_pkg::fold8(acc0, b, p) : acc0;
    fin  = cfg.reflect_out ? crc16fc_pkg::rev16(acc1) : acc1;
    if (cfg.xor_enable) begin
      fin = fin ^ cfg.xor_out;
    end

    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (pop) begin
      acc_nxt = head_op.last ? cfg.init_value : acc1;
      if (head_op.last) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.last) begin
      out_match_r <= ~head_op.short_frame & (head_op.rx_crc == fin);
      out_crc_r   <= fin;
      out_short_r <= head_op.short_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= crc16fc_pkg::InitValueReset;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_crc_match    = out_match_r;
  assign out_computed_crc = out_crc_r;
  assign out_short_frame  = out_short_r;

endmodule
`default_nettype wire

[sv/crc16_frame_checker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_checker_unit
// Streaming CRC-16 frame checker with programmable polynomial and options.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock transaction and, on the byte flagged
// frame_end, returns one result transaction: the finalized CRC of the frame
// body, whether it equals the last two frame bytes (low byte first), and a
// short-frame flag when fewer than two bytes arrived. Sustained rate is one
// byte per cycle while in_stall is low; the eight-bit CRC update is
// combinational XOR logic in the back end. A front end keeps the two-byte
// holding window and pushes one work op per byte into a two-entry queue; the
// back end drains the queue into the accumulator and a result register, which
// loads when the frame's last op is popped. in_stall rises only when the queue is full,
// i.e. when the result register is held by out_stall. Configuration writes
// are always ready and take effect for bytes folded afterwards; write them
// only while no transaction is in flight. Reset values give Modbus CRC-16
// (0x8005 reflected, init 0xFFFF, no final XOR).
// ----------------------------------------------------------------------------
module crc16_frame_checker_unit #(
  parameter int unsigned QUEUE_DEPTH = crc16fc_pkg::QueueDepth
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // byte stream
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_frame_start,
  input  wire logic                            in_frame_end,
  // results
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_crc_match,
  output logic [15:0]                          out_computed_crc,
  output logic                                 out_short_frame,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [crc16fc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [15:0]                     cfg_data
);

  crc16fc_pkg::cfg_t cfg_r, cfg_nxt;
  crc16fc_pkg::op_t  push_op, head_op;
  logic              q_full, q_push, q_pop, head_valid;

  // register file never back-pressures
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        crc16fc_pkg::CFG_POLY:         cfg_nxt.poly         = cfg_data;
        crc16fc_pkg::CFG_REFLECT_POLY: cfg_nxt.reflect_poly = cfg_data[0];
        crc16fc_pkg::CFG_INIT_VALUE:   cfg_nxt.init_value   = cfg_data;
        crc16fc_pkg::CFG_REFLECT_IN:   cfg_nxt.reflect_in   = cfg_data[0];
        crc16fc_pkg::CFG_REFLECT_OUT:  cfg_nxt.reflect_out  = cfg_data[0];
        crc16fc_pkg::CFG_XOR_ENABLE:   cfg_nxt.xor_enable   = cfg_data[0];
        crc16fc_pkg::CFG_XOR_OUT:      cfg_nxt.xor_out      = cfg_data;
        default:                       cfg_nxt              = cfg_r; // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly         <= crc16fc_pkg::PolyReset;
      cfg_r.reflect_poly <= crc16fc_pkg::ReflectPolyReset;
      cfg_r.init_value   <= crc16fc_pkg::InitValueReset;
      cfg_r.reflect_in   <= crc16fc_pkg::ReflectInReset;
      cfg_r.reflect_out  <= crc16fc_pkg::ReflectOutReset;
      cfg_r.xor_enable   <= crc16fc_pkg::XorEnableReset;
      cfg_r.xor_out      <= crc16fc_pkg::XorOutReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: window and op issue
  crc16fc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .in_frame_end   (in_frame_end),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (push_op)
  );

  // decoupling queue
  crc16fc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // back: accumulator and result register
  crc16fc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head_valid       (head_valid),
    .head_op          (head_op),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_crc_match    (out_crc_match),
    .out_computed_crc (out_computed_crc),
    .out_short_frame  (out_short_frame)
  );

endmodule
`default_nettype wire
